FILE: design/qslerp_pkg.sv
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared types, constants and conversion functions for the quaternion slerp.
// ----------------------------------------------------------------------------
`default_nettype none

package qslerp_pkg;

   localparam int COMP_W   = 16;
   localparam int Q14_DN   = (COMP_W >= 16) ? COMP_W - 16 : 0;
   localparam int Q14_UP   = (COMP_W >= 16) ? 0 : 16 - COMP_W;
   localparam int FQ_DEPTH = 4;
   localparam int FQ_PTR_W = $clog2(FQ_DEPTH);

   localparam int LEN_ROOT_BITS = 28;
   localparam int DIV_BITS      = 15;
   localparam int SIN_ROOT_BITS = 31;
   localparam int ATAN_COUNT    = 32;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_THRESHOLD = 1'b0;
   localparam logic [14:0] THRESHOLD_RESET = 15'd16376;

   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

   localparam logic signed [51:0] OUT_HI = (52'sd1 <<< (COMP_W - 1)) - 52'sd1;
   localparam logic signed [51:0] OUT_LO = -OUT_HI - 52'sd1;

   localparam logic [31:0] ATAN_Q30 [0:ATAN_COUNT-1] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic signed [COMP_W-1:0] from_x;
      logic signed [COMP_W-1:0] from_y;
      logic signed [COMP_W-1:0] from_z;
      logic signed [COMP_W-1:0] from_w;
      logic signed [COMP_W-1:0] to_x;
      logic signed [COMP_W-1:0] to_y;
      logic signed [COMP_W-1:0] to_z;
      logic signed [COMP_W-1:0] to_w;
      logic [14:0]              blend;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] out_x;
      logic signed [COMP_W-1:0] out_y;
      logic signed [COMP_W-1:0] out_z;
      logic signed [COMP_W-1:0] out_w;
      logic                     used_linear;
      logic                     degenerate;
   } rsp_type;

   typedef struct packed {
      logic [3:0][COMP_W-1:0] raw;
      logic [3:0][15:0]       f;
      logic [3:0][15:0]       d;
      logic [14:0]            blend;
      logic                   linear;
      logic [29:0]            dot;
   } fq_type;

   function automatic logic [15:0] q14_in(input logic [COMP_W-1:0] raw);
      logic signed [31:0] e;
      e = 32'($signed(raw));
      e = (e >>> Q14_DN) <<< Q14_UP;
      return e[15:0];
   endfunction

   function automatic logic [COMP_W-1:0] q14_out(input logic signed [51:0] v);
      logic signed [51:0] c;
      c = v;
      if (c > 52'sd65536) c = 52'sd65536;
      if (c < -52'sd65536) c = -52'sd65536;
      c = (c <<< Q14_DN) >>> Q14_UP;
      if (c > OUT_HI) c = OUT_HI;
      if (c < OUT_LO) c = OUT_LO;
      return c[COMP_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: design/quaternion_slerp.sv
// ----------------------------------------------------------------------------
// quaternion_slerp
// Fixed-point spherical interpolation between two Q1.14 quaternions.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_stall   req_data  (req_type)
// rsp       out        rsp_valid / rsp_stall   rsp_data  (rsp_type)
// csr       in/out     psel/penable/pready     paddr, pwdata, prdata
//
// One request per cycle is sustained while rsp_stall stays low; every step is a
// register stage of the back-end pipeline, whose depth is 87 + 2*ANGLE_ITERATIONS
// stages. A request passes through two front stages and the queue into the
// back-end pipeline, whose last stage offers the response.
// Reset is synchronous; it empties the queue and pipelines and loads the
// threshold with 16376.
// rsp_stall freezes the back end; the front end keeps filling its two stages
// and a 4-entry queue and raises req_stall once its second stage and the queue are full.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_slerp import qslerp_pkg::*; #(
   parameter int ANGLE_ITERATIONS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   logic [14:0] thr_ff;
   logic        fq_push, fq_pop, fq_full, fq_empty;
   fq_type      fq_item, fq_head;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else if (psel && penable && pwrite && paddr[2] == CSR_IDX_THRESHOLD) begin
         thr_ff <= pwdata[14:0];
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_IDX_THRESHOLD: prdata = {17'b0, thr_ff};
         default:           prdata = '0;
      endcase
   end

   qslerp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .threshold (thr_ff),
      .fq_push   (fq_push),
      .fq_item   (fq_item),
      .fq_full   (fq_full)
   );

   qslerp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_item (fq_item),
      .pop       (fq_pop),
      .head      (fq_head),
      .full      (fq_full),
      .empty     (fq_empty)
   );

   qslerp_back #(
      .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .fq_empty  (fq_empty),
      .fq_head   (fq_head),
      .fq_pop    (fq_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: design/qslerp_front.sv
// ----------------------------------------------------------------------------
// qslerp_front
// Accepts requests, forms the dot product and picks the linear or slerp path.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_front import qslerp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   input  wire logic [14:0] threshold,
   output logic             fq_push,
   output fq_type           fq_item,
   input  wire logic        fq_full
);

   typedef struct packed {
      logic [3:0][COMP_W-1:0] raw;
      logic [3:0][15:0]       f;
      logic [3:0][15:0]       d;
      logic [14:0]            blend;
      logic [3:0][31:0]       prod;
   } fs1_type;

   fs1_type s1_ff, s1_in;
   fq_type  s2_ff, s2_in;
   logic    s1_vld_ff, s2_vld_ff;
   logic    fe;

   logic signed [33:0] dot;

   assign fe        = !s2_vld_ff || !fq_full;
   assign req_stall = !fe;
   assign fq_push   = s2_vld_ff && !fq_full;
   assign fq_item   = s2_ff;

   always_comb begin
      s1_in.raw[0] = req_data.from_x;
      s1_in.raw[1] = req_data.from_y;
      s1_in.raw[2] = req_data.from_z;
      s1_in.raw[3] = req_data.from_w;
      s1_in.d[0]   = q14_in(req_data.to_x);
      s1_in.d[1]   = q14_in(req_data.to_y);
      s1_in.d[2]   = q14_in(req_data.to_z);
      s1_in.d[3]   = q14_in(req_data.to_w);
      s1_in.blend  = req_data.blend;
      for (int i = 0; i < 4; i++) begin
         s1_in.f[i]    = q14_in(s1_in.raw[i]);
         s1_in.prod[i] = 32'($signed(s1_in.f[i]) * $signed(s1_in.d[i]));
      end
   end

   always_comb begin
      dot = 34'($signed(s1_ff.prod[0])) + 34'($signed(s1_ff.prod[1]))
          + 34'($signed(s1_ff.prod[2])) + 34'($signed(s1_ff.prod[3]));
      s2_in.raw    = s1_ff.raw;
      s2_in.f      = s1_ff.f;
      s2_in.d      = s1_ff.d;
      s2_in.blend  = s1_ff.blend;
      s2_in.linear = dot > $signed({5'b0, threshold, 14'b0});
      if (dot > 34'sd268435456) begin
         s2_in.dot = 30'd268435456;
      end else if (dot < -34'sd268435456) begin
         s2_in.dot = 30'(-34'sd268435456);
      end else begin
         s2_in.dot = dot[29:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (fe) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fe) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/qslerp_fifo.sv
// ----------------------------------------------------------------------------
// qslerp_fifo
// Short queue between the classifying front end and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_fifo import qslerp_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire fq_type push_item,
   input  wire logic   pop,
   output fq_type      head,
   output logic        full,
   output logic        empty
);

   fq_type              mem_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0] wr_ff, rd_ff;
   logic [FQ_PTR_W:0]   cnt_ff;

   assign full  = cnt_ff == (FQ_PTR_W + 1)'(FQ_DEPTH);
   assign empty = cnt_ff == '0;
   assign head  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_item;
   end

endmodule

`default_nettype wire

FILE: design/qslerp_back.sv
// ----------------------------------------------------------------------------
// qslerp_back
// Pipelined arithmetic: normalization, square roots, division and CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_back import qslerp_pkg::*; #(
   parameter int ANGLE_ITERATIONS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   fq_empty,
   input  wire fq_type fq_head,
   output logic        fq_pop,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   output rsp_type     rsp_data
);

   localparam int N         = ANGLE_ITERATIONS;
   localparam int ST_PROD   = 0;
   localparam int ST_V      = 1;
   localparam int ST_SQ     = 2;
   localparam int ST_SUM    = 3;
   localparam int ST_LEN0   = 4;
   localparam int ST_DIV0   = ST_LEN0 + LEN_ROOT_BITS;
   localparam int ST_U      = ST_DIV0 + 1 + DIV_BITS;
   localparam int ST_SARG   = ST_U + 1;
   localparam int ST_SQRT0  = ST_SARG + 1;
   localparam int ST_ACOS0  = ST_SQRT0 + SIN_ROOT_BITS;
   localparam int ST_TH     = ST_ACOS0 + 1 + N;
   localparam int ST_RED    = ST_TH + 1;
   localparam int ST_SC0    = ST_RED + 1;
   localparam int ST_MUL    = ST_SC0 + N;
   localparam int ST_OUT    = ST_MUL + 1;
   localparam int LAST      = ST_OUT + 1;

   typedef struct packed {
      logic [3:0][COMP_W-1:0] raw;
      logic [3:0][15:0]       f;
      logic [3:0][15:0]       d;
      logic [14:0]            blend;
      logic                   linear;
      logic [29:0]            dot;
      logic [3:0][45:0]       prod;
      logic [3:0][26:0]       v;
      logic [3:0][53:0]       sq;
      logic [61:0]            rn;
      logic [61:0]            rr;
      logic [27:0]            len;
      logic                   zero;
      logic [3:0][42:0]       rem;
      logic [3:0][14:0]       quo;
      logic [3:0]             vneg;
      logic [3:0][15:0]       u;
      logic [61:0]            csq;
      logic [33:0]            cx;
      logic [33:0]            cy;
      logic [33:0]            cz;
      logic [49:0]            tprod;
      logic                   neg;
      logic [33:0]            sx;
      logic [33:0]            sy;
      logic [35:0]            sz;
      logic [3:0][49:0]       mf;
      logic [3:0][49:0]       mu;
      rsp_type                res;
   } work_type;

   work_type    pipe_ff [0:LAST];
   work_type    nx_in   [0:LAST-1];
   work_type    head_in;
   logic [LAST:0] vld_ff;
   logic        adv;

   assign adv       = !vld_ff[LAST] || !rsp_stall;
   assign fq_pop    = adv && !fq_empty;
   assign rsp_valid = vld_ff[LAST];
   assign rsp_data  = pipe_ff[LAST].res;

   always_comb begin
      head_in        = '0;
      head_in.raw    = fq_head.raw;
      head_in.f      = fq_head.f;
      head_in.d      = fq_head.d;
      head_in.blend  = fq_head.blend;
      head_in.linear = fq_head.linear;
      head_in.dot    = fq_head.dot;
   end

   for (genvar k = 0; k < LAST; k++) begin : g_stage
      if (k == ST_PROD) begin : g_prod
         logic signed [16:0] dmf [4];
         logic signed [45:0] pl  [4];
         logic signed [45:0] ps  [4];
         always_comb begin
            nx_in[k] = pipe_ff[k];
            for (int i = 0; i < 4; i++) begin
               dmf[i] = 17'($signed(pipe_ff[k].d[i])) - 17'($signed(pipe_ff[k].f[i]));
               pl[i]  = dmf[i] * $signed({1'b0, pipe_ff[k].blend});
               ps[i]  = $signed(pipe_ff[k].f[i]) * $signed(pipe_ff[k].dot);
               nx_in[k].prod[i] = pipe_ff[k].linear ? pl[i] : ps[i];
            end
         end
      end else if (k == ST_V) begin : g_vec
         logic signed [46:0] fs [4];
         logic signed [46:0] ds [4];
         logic signed [46:0] t  [4];
         always_comb begin
            nx_in[k] = pipe_ff[k];
            for (int i = 0; i < 4; i++) begin
               fs[i] = $signed(pipe_ff[k].f[i]);
               ds[i] = $signed(pipe_ff[k].d[i]);
               if (pipe_ff[k].linear) begin
                  t[i] = ((fs[i] <<< 14) + $signed(pipe_ff[k].prod[i])) >>> 7;
               end else begin
                  t[i] = ((ds[i] <<< 28) - $signed(pipe_ff[k].prod[i])) >>> 21;
               end
               nx_in[k].v[i] = t[i][26:0];
            end
         end
      end else if (k == ST_SQ) begin : g_sq
         logic signed [26:0] vs [4];
         logic signed [53:0] p  [4];
         always_comb begin
            nx_in[k] = pipe_ff[k];
            for (int i = 0; i < 4; i++) begin
               vs[i] = $signed(pipe_ff[k].v[i]);
               p[i]  = vs[i] * vs[i];
               nx_in[k].sq[i] = p[i];
            end
         end
      end else if (k == ST_SUM) begin : g_sum
         always_comb begin
            nx_in[k]    = pipe_ff[k];
            nx_in[k].rn = 62'(pipe_ff[k].sq[0]) + 62'(pipe_ff[k].sq[1])
                        + 62'(pipe_ff[k].sq[2]) + 62'(pipe_ff[k].sq[3]);
            nx_in[k].rr = '0;
         end
      end else if ((k >= ST_LEN0 && k < ST_DIV0) ||
                   (k >= ST_SQRT0 && k < ST_ACOS0)) begin : g_root
         localparam int I = (k < ST_DIV0) ? ST_DIV0 - 1 - k : ST_ACOS0 - 1 - k;
         localparam logic [61:0] B = 62'(1) << (2 * I);
         logic [61:0] t;
         always_comb begin
            nx_in[k] = pipe_ff[k];
            t = pipe_ff[k].rr + B;
            if (pipe_ff[k].rn >= t) begin
               nx_in[k].rn = pipe_ff[k].rn - t;
               nx_in[k].rr = (pipe_ff[k].rr >> 1) + B;
            end else begin
               nx_in[k].rr = pipe_ff[k].rr >> 1;
            end
         end
      end else if (k == ST_DIV0) begin : g_div_init
         logic [26:0] a [4];
         always_comb begin
            nx_in[k]      = pipe_ff[k];
            nx_in[k].len  = pipe_ff[k].rr[27:0];
            nx_in[k].zero = pipe_ff[k].rr == '0;
            for (int i = 0; i < 4; i++) begin
               nx_in[k].vneg[i] = pipe_ff[k].v[i][26];
               a[i] = pipe_ff[k].v[i][26] ? 27'(-$signed(pipe_ff[k].v[i]))
                                          : pipe_ff[k].v[i];
               nx_in[k].rem[i] = (43'(a[i]) << 14) + 43'(pipe_ff[k].rr[27:1]);
               nx_in[k].quo[i] = '0;
            end
         end
      end else if (k > ST_DIV0 && k < ST_U) begin : g_div
         localparam int J = ST_U - 1 - k;
         logic [42:0] dv;
         always_comb begin
            nx_in[k] = pipe_ff[k];
            dv = 43'(pipe_ff[k].len) << J;
            for (int i = 0; i < 4; i++) begin
               if (pipe_ff[k].rem[i] >= dv) begin
                  nx_in[k].rem[i]    = pipe_ff[k].rem[i] - dv;
                  nx_in[k].quo[i][J] = 1'b1;
               end
            end
         end
      end else if (k == ST_U) begin : g_unit
         logic signed [31:0] c;
         logic signed [63:0] p;
         always_comb begin
            nx_in[k] = pipe_ff[k];
            for (int i = 0; i < 4; i++) begin
               nx_in[k].u[i] = pipe_ff[k].vneg[i] ? 16'(-{1'b0, pipe_ff[k].quo[i]})
                                                  : {1'b0, pipe_ff[k].quo[i]};
            end
            c = $signed({pipe_ff[k].dot, 2'b00});
            p = c * c;
            nx_in[k].csq = p[61:0];
         end
      end else if (k == ST_SARG) begin : g_sarg
         always_comb begin
            nx_in[k]    = pipe_ff[k];
            nx_in[k].rn = (62'(1) << 60) - pipe_ff[k].csq;
            nx_in[k].rr = '0;
         end
      end else if (k == ST_ACOS0) begin : g_acos_init
         logic signed [33:0] c;
         logic signed [33:0] s;
         always_comb begin
            nx_in[k] = pipe_ff[k];
            c = $signed({pipe_ff[k].dot, 2'b00});
            s = $signed({3'b000, pipe_ff[k].rr[30:0]});
            if (c < 0) begin
               nx_in[k].cx = s;
               nx_in[k].cy = -c;
               nx_in[k].cz = HALF_PI_Q30[33:0];
            end else begin
               nx_in[k].cx = c;
               nx_in[k].cy = s;
               nx_in[k].cz = '0;
            end
         end
      end else if (k > ST_ACOS0 && k < ST_TH) begin : g_acos
         localparam int I = k - ST_ACOS0 - 1;
         localparam logic signed [33:0] AT = $signed({2'b00, ATAN_Q30[I]});
         logic signed [33:0] x, y, z;
         always_comb begin
            nx_in[k] = pipe_ff[k];
            x = $signed(pipe_ff[k].cx);
            y = $signed(pipe_ff[k].cy);
            z = $signed(pipe_ff[k].cz);
            if (y > 0) begin
               nx_in[k].cx = x + (y >>> I);
               nx_in[k].cy = y - (x >>> I);
               nx_in[k].cz = z + AT;
            end else begin
               nx_in[k].cx = x - (y >>> I);
               nx_in[k].cy = y + (x >>> I);
               nx_in[k].cz = z - AT;
            end
         end
      end else if (k == ST_TH) begin : g_theta
         logic signed [49:0] p;
         always_comb begin
            nx_in[k]       = pipe_ff[k];
            p              = $signed(pipe_ff[k].cz) * $signed({1'b0, pipe_ff[k].blend});
            nx_in[k].tprod = p;
         end
      end else if (k == ST_RED) begin : g_reduce
         logic signed [49:0] sh;
         logic signed [35:0] z;
         logic               ng;
         always_comb begin
            nx_in[k] = pipe_ff[k];
            sh = $signed(pipe_ff[k].tprod) >>> 14;
            z  = sh[35:0];
            ng = 1'b0;
            for (int r = 0; r < 3; r++) begin
               if (z > HALF_PI_Q30) begin
                  z  = z - PI_Q30;
                  ng = !ng;
               end
            end
            nx_in[k].sz  = z;
            nx_in[k].neg = ng;
            nx_in[k].sx  = GAIN_Q30;
            nx_in[k].sy  = '0;
         end
      end else if (k >= ST_SC0 && k < ST_MUL) begin : g_sincos
         localparam int I = k - ST_SC0;
         localparam logic signed [35:0] AT = $signed({4'b0000, ATAN_Q30[I]});
         logic signed [33:0] x, y;
         logic signed [35:0] z;
         always_comb begin
            nx_in[k] = pipe_ff[k];
            x = $signed(pipe_ff[k].sx);
            y = $signed(pipe_ff[k].sy);
            z = $signed(pipe_ff[k].sz);
            if (z >= 0) begin
               nx_in[k].sx = x - (y >>> I);
               nx_in[k].sy = y + (x >>> I);
               nx_in[k].sz = z - AT;
            end else begin
               nx_in[k].sx = x + (y >>> I);
               nx_in[k].sy = y - (x >>> I);
               nx_in[k].sz = z + AT;
            end
         end
      end else if (k == ST_MUL) begin : g_mul
         logic signed [33:0] co, si;
         logic signed [49:0] pf [4];
         logic signed [49:0] pu [4];
         always_comb begin
            nx_in[k] = pipe_ff[k];
            co = pipe_ff[k].neg ? -$signed(pipe_ff[k].sx) : $signed(pipe_ff[k].sx);
            si = pipe_ff[k].neg ? -$signed(pipe_ff[k].sy) : $signed(pipe_ff[k].sy);
            for (int i = 0; i < 4; i++) begin
               pf[i] = $signed(pipe_ff[k].f[i]) * co;
               pu[i] = $signed(pipe_ff[k].u[i]) * si;
               nx_in[k].mf[i] = pf[i];
               nx_in[k].mu[i] = pu[i];
            end
         end
      end else begin : g_out
         logic signed [51:0]      sm  [4];
         logic signed [51:0]      val [4];
         logic [3:0][COMP_W-1:0]  o;
         always_comb begin
            nx_in[k] = pipe_ff[k];
            for (int i = 0; i < 4; i++) begin
               sm[i]  = ($signed(pipe_ff[k].mf[i]) + $signed(pipe_ff[k].mu[i])
                        + 52'sd536870912) >>> 30;
               val[i] = pipe_ff[k].linear ? 52'($signed(pipe_ff[k].u[i])) : sm[i];
               o[i]   = pipe_ff[k].zero ? pipe_ff[k].raw[i] : q14_out(val[i]);
            end
            nx_in[k].res.out_x       = o[0];
            nx_in[k].res.out_y       = o[1];
            nx_in[k].res.out_z       = o[2];
            nx_in[k].res.out_w       = o[3];
            nx_in[k].res.used_linear = pipe_ff[k].linear;
            nx_in[k].res.degenerate  = pipe_ff[k].zero;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:0], fq_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff[0] <= head_in;
         for (int k = 0; k < LAST; k++) begin
            pipe_ff[k+1] <= nx_in[k];
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/qslerp_checker.sv
// ----------------------------------------------------------------------------
// qslerp_checker
// Port-level checks for the quaternion slerp, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_checker import qslerp_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire rsp_type               rsp_data,
   input wire logic                  psel,
   input wire logic                  penable,
   input wire logic                  pwrite,
   input wire logic [CSR_ADDR_W-1:0] paddr,
   input wire logic [31:0]           pwdata,
   input wire logic [31:0]           prdata,
   input wire logic                  pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Result dropped while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("Result changed while stalled.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result shown right after reset.");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && paddr[2] == CSR_IDX_THRESHOLD |=>
      paddr[2] != CSR_IDX_THRESHOLD || prdata == {17'b0, $past(pwdata[14:0])})
      else $error("Threshold readback differs from the written value.");

endmodule

bind quaternion_slerp qslerp_checker u_checker (.*);

`default_nettype wire
